// ----- rtl/mrope_pkg.sv -----
// Shared types, constants and tables for the multimodal rotary cos/sin generator.
`timescale 1ns / 1ps

package mrope_pkg;

    localparam int MAX_HALF_DIM = 64;
    localparam int POS_BITS     = 24;
    localparam int OUT_BITS     = 16;

    localparam int FREQ_W       = 32;
    localparam int FIDX_W       = 6;
    localparam int DIM_W        = 6;
    localparam int SEC_W        = 7;
    localparam int AXIS_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int CNT_W        = 10;

    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;
    localparam int ZW           = 33;
    localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
    localparam logic [31:0] EIGHTH_TURN = 32'h20000000;

    localparam logic [CFG_IDX_W-1:0] CFG_STYLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_T  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_H  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_W  = 2'd3;

    localparam logic [SEC_W-1:0] SEC_T_RESET = 7'd16;
    localparam logic [SEC_W-1:0] SEC_H_RESET = 7'd24;
    localparam logic [SEC_W-1:0] SEC_W_RESET = 7'd24;

    localparam logic [AXIS_W-1:0] AXIS_TEMPORAL = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_HEIGHT   = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_WIDTH    = 2'd2;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_GEN  = 1'b1;

    localparam logic STYLE_BLOCK  = 1'b0;
    localparam logic STYLE_STRIDE = 1'b1;

    typedef struct packed {
        logic             style;
        logic [SEC_W-1:0] sec_t;
        logic [SEC_W-1:0] sec_h;
        logic [SEC_W-1:0] sec_w;
    } cfg_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic [DIM_W-1:0]  dim;
        logic [AXIS_W-1:0] axis;
        logic              last_tok;
        logic              last_seq;
    } side_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    // arctangent of 2^-k in Q0.32 turns
    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] a;
        unique case (k)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            default: a = 32'h00000051;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/multimodal_rope_cos_sin_generator_top.sv -----
// Top level of the multimodal rotary position cos/sin generator.
`timescale 1ns / 1ps

// A load beat (tuser 0) writes one frequency table entry; it is held off
// until every queued position beat has finished reading the table. A position
// beat (tuser 1) yields half_dim result beats (64 at reset), one per cycle
// while the output is taken, paced by the index counter of the sequencer; the
// results come out of the multiply and 24-step CORDIC pipeline. Up to two
// position beats wait in the queue while a token is in progress. The table has
// no reset: read only entries that were loaded.
module multimodal_rope_cos_sin_generator_top #(
    parameter int MAX_HALF_DIM = mrope_pkg::MAX_HALF_DIM,
    parameter int POS_BITS     = mrope_pkg::POS_BITS,
    parameter int OUT_BITS     = mrope_pkg::OUT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // freq_index, freq_value, pos_temporal, pos_height, pos_width, zero fill
    input  logic [((38+3*POS_BITS+7)/8)*8-1:0]  s_axis_tdata,
    // action
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // dim_index, source_axis, cos_value, sin_value, zero fill
    output logic [((8+2*OUT_BITS+7)/8)*8-1:0]   m_axis_tdata,
    // last_of_sequence
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [mrope_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mrope_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IN_DATA_W  = ((38 + 3*POS_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((8 + 2*OUT_BITS + 7) / 8) * 8;
    localparam int AW         = $clog2(MAX_HALF_DIM);

    mrope_pkg::cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mrope_pkg::CFG_STYLE: cfg_next.style = cfg_data[0];
                mrope_pkg::CFG_SEC_T: cfg_next.sec_t = cfg_data;
                mrope_pkg::CFG_SEC_H: cfg_next.sec_h = cfg_data;
                mrope_pkg::CFG_SEC_W: cfg_next.sec_w = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.style <= mrope_pkg::STYLE_BLOCK;
            cfg_reg.sec_t <= mrope_pkg::SEC_T_RESET;
            cfg_reg.sec_h <= mrope_pkg::SEC_H_RESET;
            cfg_reg.sec_w <= mrope_pkg::SEC_W_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mrope_pkg::q_status_t         q_status;
    logic                         q_push;
    logic                         q_pop;
    logic [3*POS_BITS:0]          q_push_data;
    logic [3*POS_BITS:0]          q_pop_data;
    logic                         back_busy;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [mrope_pkg::FREQ_W-1:0] ram_wdata;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [mrope_pkg::FREQ_W-1:0] ram_rdata;

    mrope_front #(
        .MAX_HALF_DIM (MAX_HALF_DIM),
        .POS_BITS     (POS_BITS),
        .IN_DATA_W    (IN_DATA_W)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_status      (q_status),
        .back_busy     (back_busy),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .q_push        (q_push),
        .q_data        (q_push_data)
    );

    mrope_queue #(
        .WIDTH (3*POS_BITS + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    mrope_ram #(
        .WIDTH (mrope_pkg::FREQ_W),
        .DEPTH (MAX_HALF_DIM)
    ) u_freq_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mrope_back #(
        .MAX_HALF_DIM (MAX_HALF_DIM),
        .POS_BITS     (POS_BITS),
        .OUT_BITS     (OUT_BITS),
        .OUT_DATA_W   (OUT_DATA_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_status      (q_status),
        .q_data        (q_pop_data),
        .q_pop         (q_pop),
        .busy          (back_busy),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- rtl/mrope_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mrope_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mrope_queue.sv -----
// Two-entry queue carrying position beats from the front end to the sequencer.
`timescale 1ns / 1ps

module mrope_queue #(
    parameter int WIDTH = 73
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     push_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     pop_data,
    output mrope_pkg::q_status_t status
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);

endmodule

// ----- rtl/mrope_front.sv -----
// Input stage: takes beats, writes table loads, queues position beats.
`timescale 1ns / 1ps

module mrope_front #(
    parameter int MAX_HALF_DIM = mrope_pkg::MAX_HALF_DIM,
    parameter int POS_BITS     = mrope_pkg::POS_BITS,
    parameter int IN_DATA_W    = 112
) (
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [IN_DATA_W-1:0]            s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    input  mrope_pkg::q_status_t            q_status,
    input  logic                            back_busy,
    output logic                            ram_we,
    output logic [$clog2(MAX_HALF_DIM)-1:0] ram_waddr,
    output logic [mrope_pkg::FREQ_W-1:0]    ram_wdata,
    output logic                            q_push,
    output logic [3*POS_BITS:0]             q_data
);

    localparam int FV_LO = mrope_pkg::FIDX_W;
    localparam int PT_LO = FV_LO + mrope_pkg::FREQ_W;

    logic [mrope_pkg::FIDX_W-1:0] freq_index;
    logic                         load_ok;
    logic                         accept;

    assign freq_index = s_axis_tdata[mrope_pkg::FIDX_W-1:0];
    // a load waits until every queued position has read the table
    assign load_ok    = q_status.empty && !back_busy;

    always_comb
    begin
        if (s_axis_tuser == mrope_pkg::ACTION_GEN)
        begin
            s_axis_tready = !q_status.full;
        end
        else
        begin
            s_axis_tready = load_ok;
        end
    end

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign ram_we    = accept && (s_axis_tuser == mrope_pkg::ACTION_LOAD)
                       && (32'(freq_index) < MAX_HALF_DIM);
    assign ram_waddr = ($clog2(MAX_HALF_DIM))'(freq_index);
    assign ram_wdata = s_axis_tdata[FV_LO +: mrope_pkg::FREQ_W];
    assign q_push    = accept && (s_axis_tuser == mrope_pkg::ACTION_GEN);
    assign q_data    = {s_axis_tlast, s_axis_tdata[PT_LO +: 3*POS_BITS]};

endmodule

// ----- rtl/mrope_back.sv -----
// Sequencer, phase multiplier, CORDIC pipeline and output register.
`timescale 1ns / 1ps

module mrope_back #(
    parameter int MAX_HALF_DIM = mrope_pkg::MAX_HALF_DIM,
    parameter int POS_BITS     = mrope_pkg::POS_BITS,
    parameter int OUT_BITS     = mrope_pkg::OUT_BITS,
    parameter int OUT_DATA_W   = 40
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mrope_pkg::cfg_t                 cfg,
    input  mrope_pkg::q_status_t            q_status,
    input  logic [3*POS_BITS:0]             q_data,
    output logic                            q_pop,
    output logic                            busy,
    output logic                            ram_re,
    output logic [$clog2(MAX_HALF_DIM)-1:0] ram_raddr,
    input  logic [mrope_pkg::FREQ_W-1:0]    ram_rdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [OUT_DATA_W-1:0]           m_axis_tdata,
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);

    localparam int AW    = $clog2(MAX_HALF_DIM);
    localparam int HW    = $clog2(MAX_HALF_DIM + 1);
    localparam int NS    = mrope_pkg::CORDIC_STEPS;
    localparam int CW    = mrope_pkg::CW;
    localparam int ZW    = mrope_pkg::ZW;
    localparam int CNT_W = mrope_pkg::CNT_W;
    localparam int SH    = 31 - OUT_BITS;
    localparam logic signed [CW:0] SAT_HI = (CW+1)'(2**(OUT_BITS-1) - 1);
    localparam logic signed [CW:0] SAT_LO = -SAT_HI - (CW+1)'(1);

    function automatic logic [OUT_BITS-1:0] to_out(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        t = {v[CW-1], v} + (CW+1)'(2**(SH-1));
        t = t >>> SH;
        if (t > SAT_HI)
        begin
            t = SAT_HI;
        end
        else if (t < SAT_LO)
        begin
            t = SAT_LO;
        end
        return OUT_BITS'(t);
    endfunction

    // ---------------- sequencer ----------------
    mrope_pkg::seq_state_t state_reg, state_next;
    logic [HW-1:0]         i_reg, i_next;
    logic [1:0]            mod3_reg, mod3_next;
    logic [POS_BITS-1:0]   pos_reg [3];
    logic                  last_reg;

    logic                  en;
    logic                  issue;
    logic                  issue_last;
    logic [CNT_W-1:0]      sum_sec;
    logic [HW-1:0]         half_dim;
    logic [CNT_W-1:0]      i_wide;
    logic [mrope_pkg::AXIS_W-1:0] axis;

    assign en       = !m_axis_tvalid || m_axis_tready;
    assign sum_sec  = CNT_W'(cfg.sec_t) + CNT_W'(cfg.sec_h) + CNT_W'(cfg.sec_w);
    assign half_dim = (sum_sec > CNT_W'(MAX_HALF_DIM)) ? HW'(MAX_HALF_DIM) : HW'(sum_sec);
    assign i_wide   = CNT_W'(i_reg);
    assign issue    = (state_reg == mrope_pkg::SEQ_RUN) && en;
    assign issue_last = (i_reg + HW'(1) == half_dim);

    always_comb
    begin
        if (cfg.style == mrope_pkg::STYLE_BLOCK)
        begin
            if (i_wide < CNT_W'(cfg.sec_t))
            begin
                axis = mrope_pkg::AXIS_TEMPORAL;
            end
            else if (i_wide < CNT_W'(cfg.sec_t) + CNT_W'(cfg.sec_h))
            begin
                axis = mrope_pkg::AXIS_HEIGHT;
            end
            else
            begin
                axis = mrope_pkg::AXIS_WIDTH;
            end
        end
        else
        begin
            if (mod3_reg == 2'd1 && i_wide < 3 * CNT_W'(cfg.sec_h))
            begin
                axis = mrope_pkg::AXIS_HEIGHT;
            end
            else if (mod3_reg == 2'd2 && i_wide < 3 * CNT_W'(cfg.sec_w))
            begin
                axis = mrope_pkg::AXIS_WIDTH;
            end
            else
            begin
                axis = mrope_pkg::AXIS_TEMPORAL;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrope_pkg::SEQ_IDLE:
            begin
                if (!q_status.empty && half_dim != HW'(0))
                begin
                    state_next = mrope_pkg::SEQ_RUN;
                end
            end
            mrope_pkg::SEQ_RUN:
            begin
                if (en && issue_last)
                begin
                    state_next = mrope_pkg::SEQ_IDLE;
                end
            end
            default: state_next = mrope_pkg::SEQ_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        i_next    = i_reg;
        mod3_next = mod3_reg;
        unique case (state_reg)
            mrope_pkg::SEQ_IDLE:
            begin
                q_pop     = !q_status.empty;
                i_next    = '0;
                mod3_next = 2'd0;
            end
            mrope_pkg::SEQ_RUN:
            begin
                if (en)
                begin
                    i_next    = i_reg + HW'(1);
                    mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                end
            end
            default: q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrope_pkg::SEQ_IDLE;
            i_reg     <= '0;
            mod3_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            mod3_reg  <= mod3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pos_reg[0] <= q_data[0 +: POS_BITS];
            pos_reg[1] <= q_data[POS_BITS +: POS_BITS];
            pos_reg[2] <= q_data[2*POS_BITS +: POS_BITS];
            last_reg   <= q_data[3*POS_BITS];
        end
    end

    assign busy      = (state_reg == mrope_pkg::SEQ_RUN);
    assign ram_re    = en;
    assign ram_raddr = i_reg[AW-1:0];

    // ---------------- stage 1: table read ----------------
    logic               v1_reg;
    mrope_pkg::side_t   side1_reg;
    logic [31:0]        pos1_reg;
    logic signed [POS_BITS-1:0] pos_sel;

    always_comb
    begin
        unique case (axis)
            mrope_pkg::AXIS_HEIGHT: pos_sel = pos_reg[1];
            mrope_pkg::AXIS_WIDTH:  pos_sel = pos_reg[2];
            default:                pos_sel = pos_reg[0];
        endcase
    end

    // ---------------- stage 2: phase ----------------
    logic               v2_reg;
    mrope_pkg::side_t   side2_reg;
    logic [31:0]        phase2_reg;

    // ---------------- CORDIC ----------------
    logic               vc_reg   [NS+1];
    mrope_pkg::side_t   sidec_reg[NS+1];
    logic [1:0]         qc_reg   [NS+1];
    logic signed [CW-1:0] x_reg  [NS+1];
    logic signed [CW-1:0] y_reg  [NS+1];
    logic signed [ZW-1:0] z_reg  [NS+1];

    logic [1:0]         quad;
    logic [31:0]        rem;

    assign quad = 2'((phase2_reg + mrope_pkg::EIGHTH_TURN) >> 30);
    assign rem  = phase2_reg - {quad, 30'd0};

    // ---------------- quadrant fold ----------------
    logic               vq_reg;
    mrope_pkg::side_t   sideq_reg;
    logic signed [CW-1:0] cq_reg, sq_reg;
    logic signed [CW-1:0] c_fold, s_fold;

    // ---------------- output ----------------
    logic               out_valid_reg, out_valid_next;
    mrope_pkg::side_t   out_side_reg;
    logic [OUT_BITS-1:0] out_cos_reg, out_sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            vq_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= NS; k++)
            begin
                vc_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (en)
            begin
                v1_reg    <= issue;
                v2_reg    <= v1_reg;
                vc_reg[0] <= v2_reg;
                for (int k = 0; k < NS; k++)
                begin
                    vc_reg[k+1] <= vc_reg[k];
                end
                vq_reg    <= vc_reg[NS];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (en)
        begin
            out_valid_next = vq_reg;
        end
    end

    always_comb
    begin
        unique case (qc_reg[NS])
            2'd0:    begin c_fold =  x_reg[NS]; s_fold =  y_reg[NS]; end
            2'd1:    begin c_fold = -y_reg[NS]; s_fold =  x_reg[NS]; end
            2'd2:    begin c_fold = -x_reg[NS]; s_fold = -y_reg[NS]; end
            default: begin c_fold =  y_reg[NS]; s_fold = -x_reg[NS]; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg.dim      <= mrope_pkg::DIM_W'(i_reg);
            side1_reg.axis     <= axis;
            side1_reg.last_tok <= issue_last;
            side1_reg.last_seq <= issue_last && last_reg;
            pos1_reg           <= 32'(pos_sel);

            side2_reg  <= side1_reg;
            phase2_reg <= pos1_reg * ram_rdata;

            sidec_reg[0] <= side2_reg;
            qc_reg[0]    <= quad;
            x_reg[0]     <= CW'(mrope_pkg::CORDIC_GAIN);
            y_reg[0]     <= '0;
            z_reg[0]     <= ZW'(signed'(rem));

            for (int k = 0; k < NS; k++)
            begin
                sidec_reg[k+1] <= sidec_reg[k];
                qc_reg[k+1]    <= qc_reg[k];
                if (!z_reg[k][ZW-1])
                begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - ZW'(mrope_pkg::atan_turn(k));
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + ZW'(mrope_pkg::atan_turn(k));
                end
            end

            sideq_reg <= sidec_reg[NS];
            cq_reg    <= c_fold;
            sq_reg    <= s_fold;

            out_side_reg <= sideq_reg;
            out_cos_reg  <= to_out(cq_reg);
            out_sin_reg  <= to_out(sq_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_sin_reg, out_cos_reg,
                                        out_side_reg.axis, out_side_reg.dim});
    assign m_axis_tlast  = out_side_reg.last_tok;
    assign m_axis_tuser  = out_side_reg.last_seq;

    // the counter never runs past the token length
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrope_pkg::SEQ_RUN) |-> (i_reg < half_dim))
        else $error("index counter beyond half_dim");

    // issuing the final index ends the run
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && issue_last) |=> (state_reg == mrope_pkg::SEQ_IDLE))
        else $error("sequencer kept running after final index");

    // sequence end only rides on a token end
    a_seq_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_side_reg.last_seq) |-> out_side_reg.last_tok)
        else $error("last_of_sequence without last_of_token");

endmodule
